>>> hw/rtl/double_ended_queue_defines.svh
// Assertion macros shared by the queue RTL.
// Each check is clocked on clk and held off while rst_n is low.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

`define DEQ_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant check failed");

`define DEQ_ASSERT_IMPLY(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("implication check failed");

`define DEQ_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`else

`define DEQ_ASSERT_ALWAYS(label, cond)

`define DEQ_ASSERT_IMPLY(label, pre, post)

`define DEQ_ASSERT_NEXT(label, pre, post)

`endif

`endif

>>> hw/rtl/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

  localparam int CAPACITY  = 1024;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int SUM_W     = IDX_W + 1;
  localparam int OP_W      = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_QUERY      = 3'd4
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  // Ring index addition; both operands are below CAPACITY.
  function automatic logic [IDX_W-1:0] ring_add(logic [IDX_W-1:0] base,
                                                logic [IDX_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= SUM_W'(CAPACITY)) begin
      s = s - SUM_W'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(logic [IDX_W-1:0] base);
    logic [IDX_W-1:0] r;
    if (base == '0) begin
      r = IDX_W'(CAPACITY - 1);
    end else begin
      r = base - IDX_W'(1);
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_operation, in_value
// out      output     out_valid / out_ready  out_popped_word .. out_overflow
//
// Each request is accepted in the idle state, which drives the single port of the
// ring memory, and the response state then collects its registered read data.
// A finished result sits in the output register, so the next request is taken
// while it waits. Synchronous active-low reset empties the queue at once.
// A stalled output holds the block in its response state until the slot frees.
`include "double_ended_queue_defines.svh"

module double_ended_queue
  import deq_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [OP_W-1:0]             in_operation,
  input  logic signed [WORD_BITS-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [WORD_BITS-1:0] out_popped_word,
  output logic                        out_popped_valid,
  output logic signed [WORD_BITS-1:0] out_front_word,
  output logic signed [WORD_BITS-1:0] out_back_word,
  output logic                        out_ends_valid,
  output logic [CNT_W-1:0]            out_entry_count,
  output logic                        out_is_empty,
  output logic                        out_overflow
);

  logic signed [WORD_BITS-1:0] mem [CAPACITY];
  logic signed [WORD_BITS-1:0] rd_data_r;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic signed [WORD_BITS-1:0] front_r, front_nxt;
  logic signed [WORD_BITS-1:0] back_r, back_nxt;
  logic signed [WORD_BITS-1:0] popped_r, popped_nxt;
  logic popped_valid_r, popped_valid_nxt;
  logic ovf_r, ovf_nxt;
  logic fix_front_r, fix_front_nxt;
  logic fix_back_r, fix_back_nxt;
  logic out_valid_r;

  logic in_fire;
  logic out_load;
  logic mem_we, mem_re;
  logic [IDX_W-1:0] mem_addr;
  logic [CNT_W-1:0] cnt_m2;
  logic signed [WORD_BITS-1:0] front_eff, back_eff;
  op_t op;

  assign op      = op_t'(in_operation);
  assign in_fire = in_valid && in_ready;
  assign cnt_m2  = count_r - CNT_W'(2);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_RESP: out_load = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // Pointer update and memory access for an accepted request. A pop that leaves
  // entries behind marks one end to be refreshed from memory in the response cycle.
  always_comb begin
    head_nxt         = head_r;
    count_nxt        = count_r;
    front_nxt        = front_r;
    back_nxt         = back_r;
    popped_nxt       = popped_r;
    popped_valid_nxt = popped_valid_r;
    ovf_nxt          = ovf_r;
    fix_front_nxt    = fix_front_r;
    fix_back_nxt     = fix_back_r;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    mem_addr         = head_r;

    if (state_r == S_RESP) begin
      if (fix_front_r) begin
        front_nxt = rd_data_r;
      end
      if (fix_back_r) begin
        back_nxt = rd_data_r;
      end
    end

    if (in_fire) begin
      popped_nxt       = '0;
      popped_valid_nxt = 1'b0;
      ovf_nxt          = 1'b0;
      fix_front_nxt    = 1'b0;
      fix_back_nxt     = 1'b0;
      case (op)
        OP_PUSH_FRONT: begin
          if (count_r == CNT_W'(CAPACITY)) begin
            ovf_nxt = 1'b1;
          end else begin
            head_nxt  = ring_dec(head_r);
            mem_we    = 1'b1;
            mem_addr  = ring_dec(head_r);
            count_nxt = count_r + CNT_W'(1);
            front_nxt = in_value;
            if (count_r == '0) begin
              back_nxt = in_value;
            end
          end
        end
        OP_PUSH_BACK: begin
          if (count_r == CNT_W'(CAPACITY)) begin
            ovf_nxt = 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_addr  = ring_add(head_r, count_r[IDX_W-1:0]);
            count_nxt = count_r + CNT_W'(1);
            back_nxt  = in_value;
            if (count_r == '0) begin
              front_nxt = in_value;
            end
          end
        end
        OP_POP_FRONT: begin
          if (count_r != '0) begin
            popped_nxt       = front_r;
            popped_valid_nxt = 1'b1;
            head_nxt         = ring_add(head_r, IDX_W'(1));
            count_nxt        = count_r - CNT_W'(1);
            mem_re           = 1'b1;
            mem_addr         = ring_add(head_r, IDX_W'(1));
            fix_front_nxt    = (count_r != CNT_W'(1));
          end
        end
        OP_POP_BACK: begin
          if (count_r != '0) begin
            popped_nxt       = back_r;
            popped_valid_nxt = 1'b1;
            count_nxt        = count_r - CNT_W'(1);
            mem_re           = 1'b1;
            mem_addr         = ring_add(head_r, cnt_m2[IDX_W-1:0]);
            fix_back_nxt     = (count_r != CNT_W'(1));
          end
        end
        default: begin
          // Query and unused codes leave the queue untouched.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= in_value;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_r        <= front_nxt;
    back_r         <= back_nxt;
    popped_r       <= popped_nxt;
    popped_valid_r <= popped_valid_nxt;
    ovf_r          <= ovf_nxt;
    fix_front_r    <= fix_front_nxt;
    fix_back_r     <= fix_back_nxt;
  end

  assign front_eff = fix_front_r ? rd_data_r : front_r;
  assign back_eff  = fix_back_r ? rd_data_r : back_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_popped_word  <= popped_r;
      out_popped_valid <= popped_valid_r;
      out_entry_count  <= count_r;
      out_overflow     <= ovf_r;
      if (count_r != '0) begin
        out_front_word <= front_eff;
        out_back_word  <= back_eff;
        out_ends_valid <= 1'b1;
        out_is_empty   <= 1'b0;
      end else begin
        out_front_word <= '0;
        out_back_word  <= '0;
        out_ends_valid <= 1'b0;
        out_is_empty   <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;

  `DEQ_ASSERT_ALWAYS(a_count_range, count_r <= CNT_W'(CAPACITY))
  `DEQ_ASSERT_ALWAYS(a_head_range, {1'b0, head_r} < SUM_W'(CAPACITY))
  `DEQ_ASSERT_NEXT(a_accept_to_resp, in_fire, state_r == S_RESP)
  `DEQ_ASSERT_IMPLY(a_empty_flag, out_valid_r, out_is_empty == (out_entry_count == '0))
  `DEQ_ASSERT_IMPLY(a_overflow_full, out_valid_r && out_overflow, out_entry_count == CNT_W'(CAPACITY))

endmodule
